// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the PID duty controller
// Holds the field widths, register indexes, the micro-op encoding and the
// control program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  // Field and datapath widths.
  localparam int GAIN_W     = 15;
  localparam int LIM_W      = 31;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DUTY_W     = 16;
  localparam int QUO_W      = 12;
  localparam int REM_W      = GAIN_W + QUO_W;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = SUM_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int STEP_W     = 4;
  localparam int CNT_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SUM_ERROR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_I_TERM    = 3'd6;

  // Constants of the output mapping.
  localparam logic [LIM_W-1:0]  LIM_MAX  = {LIM_W{1'b1}};
  localparam logic [DUTY_W-1:0] DUTY_MID = 16'h8000;
  localparam logic [DUTY_W-1:0] DUTY_TOP = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_BOT = 16'h0000;

  // Micro-operations executed by the datapath.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PREP,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ADD_D,
    OP_ABS,
    OP_CMP,
    OP_DIV,
    OP_OUT
  } op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [1:0] {
    JC_NONE,
    JC_NO_REQ,
    JC_LOOP,
    JC_OUT_BUSY
  } jc_t;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One control word of the program.
  typedef struct packed {
    op_t   op;
    jc_t   jc;
    step_t target;
    logic  last;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic take;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_busy;
  } stat_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_PREP = 4'd1;
  localparam step_t STEP_DIV  = 4'd8;
  localparam step_t STEP_OUT  = 4'd9;

  localparam cnt_t DIV_ITER_LAST = cnt_t'(QUO_W - 1);

  // Control program: gather terms, take the magnitude, divide, deliver.
  function automatic uword_t ucode_rom(input step_t addr);
    uword_t w;
    begin
      w = '{op: OP_IDLE, jc: JC_NONE, target: STEP_IDLE, last: 1'b1};
      case (addr)
        4'd0: w = '{op: OP_IDLE,  jc: JC_NO_REQ,   target: STEP_IDLE, last: 1'b0};
        4'd1: w = '{op: OP_PREP,  jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd2: w = '{op: OP_MUL_P, jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd3: w = '{op: OP_MUL_I, jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd4: w = '{op: OP_MUL_D, jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd5: w = '{op: OP_ADD_D, jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd6: w = '{op: OP_ABS,   jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd7: w = '{op: OP_CMP,   jc: JC_NONE,     target: STEP_IDLE, last: 1'b0};
        4'd8: w = '{op: OP_DIV,   jc: JC_LOOP,     target: STEP_DIV,  last: 1'b0};
        4'd9: w = '{op: OP_OUT,   jc: JC_OUT_BUSY, target: STEP_OUT,  last: 1'b1};
        default: w = '{op: OP_IDLE, jc: JC_NONE, target: STEP_IDLE, last: 1'b1};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pdc_sequencer.sv =====
// ----------------------------------------------------------------------------
// pdc_sequencer: step counter and control program of the PID controller
// Reads one control word per step, evaluates its jump condition and runs
// the loop counter of the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_sequencer
  import pdc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire stat_t stat,
  output ctrl_t      ctrl,
  output logic       in_ready
);

  step_t  step;
  step_t  step_next;
  cnt_t   cnt;
  uword_t uw;
  logic   taken;

  // Current control word.
  assign uw = ucode_rom(step);

  // Jump condition of the current word.
  always_comb begin
    case (uw.jc)
      JC_NONE:     taken = 1'b0;
      JC_NO_REQ:   taken = !in_valid;
      JC_LOOP:     taken = (cnt != '0);
      JC_OUT_BUSY: taken = stat.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  // Next step: jump target, program start after the last word, or fall through.
  always_comb begin
    if (taken) begin
      step_next = uw.target;
    end else if (uw.last) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = step_t'(step + 1'b1);
    end
  end

  // Step register and divider loop counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      cnt  <= '0;
    end else begin
      step <= step_next;
      if (uw.op == OP_CMP) begin
        cnt <= DIV_ITER_LAST;
      end else if (uw.op == OP_DIV && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // A request is taken only while the program waits at its first step.
  assign in_ready  = (uw.op == OP_IDLE) && !rst;
  assign ctrl.op   = uw.op;
  assign ctrl.take = in_ready && in_valid;

  // An accepted request always starts the computation in the next cycle.
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (step == STEP_PREP))
    else $error("accepted request did not start the program");

  // The loop counter is only live inside the divide loop.
  a_cnt_in_loop: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (uw.op == OP_DIV))
    else $error("loop counter active outside the divide step");

  // A delivered result returns the program to its first step.
  a_out_returns: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_OUT && !stat.out_busy) |=> (step == STEP_IDLE))
    else $error("program did not return after delivering a result");

endmodule

`default_nettype wire

// ===== rtl/pdc_datapath.sv =====
// ----------------------------------------------------------------------------
// pdc_datapath: arithmetic of the PID controller
// One shared multiplier, a wide accumulator, a restoring divider that
// produces one quotient bit per step, the controller state and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_datapath
  import pdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ctrl_t                   ctrl,
  input  wire logic [SAMPLE_WIDTH-1:0] set_point,
  input  wire logic [SAMPLE_WIDTH-1:0] process_value,
  input  wire logic [GAIN_W-1:0]       p_gain,
  input  wire logic [GAIN_W-1:0]       i_gain,
  input  wire logic [GAIN_W-1:0]       d_gain,
  input  wire logic [GAIN_W-1:0]       scale_factor,
  input  wire logic [LIM_W-1:0]        max_error,
  input  wire logic [LIM_W-1:0]        max_sum_error,
  input  wire logic [LIM_W-1:0]        i_term_cap,
  input  wire logic                    out_ready,
  output stat_t                        stat,
  output logic                         out_valid,
  output logic [DUTY_W-1:0]            duty_out
);

  localparam int SEXT_W = MUL_B_W - SAMPLE_WIDTH - 1;

  // Captured request and controller state.
  logic [SAMPLE_WIDTH-1:0]        sp;
  logic [SAMPLE_WIDTH-1:0]        pv;
  logic [SAMPLE_WIDTH-1:0]        last_sample;
  logic signed [SUM_W-1:0]        error_sum;

  // Working registers.
  logic signed [SAMPLE_WIDTH:0]   err;
  logic signed [SAMPLE_WIDTH:0]   dif;
  logic signed [MUL_B_W-1:0]      tmp;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic                           p_hi;
  logic                           p_lo;
  logic                           i_hi;
  logic                           i_lo;
  logic                           neg;
  logic                           sat;
  logic [REM_W-1:0]               rem;
  logic [REM_W-1:0]               dvs;
  logic [QUO_W-1:0]               quo;

  // Combinational values.
  logic signed [SAMPLE_WIDTH:0]   err_c;
  logic signed [MUL_B_W-1:0]      tmp_c;
  logic signed [SAMPLE_WIDTH:0]   dif_c;
  logic signed [MUL_B_W-1:0]      err_x;
  logic signed [MUL_B_W-1:0]      dif_x;
  logic signed [MUL_B_W-1:0]      lim_e;
  logic signed [MUL_B_W-1:0]      lim_s;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       mul_p;
  logic signed [ACC_W-1:0]        prod_x;
  logic signed [ACC_W-1:0]        p_sat;
  logic signed [ACC_W-1:0]        i_sat;
  logic signed [ACC_W-1:0]        pterm;
  logic signed [ACC_W-1:0]        iterm;
  logic [GAIN_W-1:0]              divisor;
  logic [ACC_W-1:0]               div_lim;
  logic [DUTY_W-1:0]              q_scaled;
  logic [DUTY_W-1:0]              duty_c;
  logic                           out_busy;

  // Error, sum candidate and measurement change.
  assign err_c = $signed({1'b0, sp}) - $signed({1'b0, pv});
  assign tmp_c = $signed({error_sum[SUM_W-1], error_sum})
               + $signed({{SEXT_W{err_c[SAMPLE_WIDTH]}}, err_c});
  assign dif_c = $signed({1'b0, last_sample}) - $signed({1'b0, pv});
  assign err_x = $signed({{SEXT_W{err[SAMPLE_WIDTH]}}, err});
  assign dif_x = $signed({{SEXT_W{dif[SAMPLE_WIDTH]}}, dif});
  assign lim_e = $signed({2'b00, max_error});
  assign lim_s = $signed({2'b00, max_sum_error});

  // Shared multiplier operand selection.
  always_comb begin
    case (ctrl.op)
      OP_MUL_P: begin
        mul_a = $signed({1'b0, p_gain});
        mul_b = err_x;
      end
      OP_MUL_I: begin
        mul_a = $signed({1'b0, i_gain});
        mul_b = tmp;
      end
      OP_MUL_D: begin
        mul_a = $signed({1'b0, d_gain});
        mul_b = dif_x;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Term selection with saturation of the P and I terms.
  assign prod_x = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign p_sat  = $signed({{(ACC_W-LIM_W){1'b0}}, LIM_MAX});
  assign i_sat  = $signed({{(ACC_W-LIM_W){1'b0}}, i_term_cap});
  assign pterm  = p_hi ? p_sat : (p_lo ? -p_sat : prod_x);
  assign iterm  = i_hi ? i_sat : (i_lo ? -i_sat : prod_x);

  // Divisor and the bound at or beyond which the duty saturates.
  assign divisor = (scale_factor == '0) ? GAIN_W'(1) : scale_factor;
  assign div_lim = {{(ACC_W-REM_W){1'b0}}, divisor, {QUO_W{1'b0}}};

  // Output mapping: mid scale plus eight times the signed quotient.
  assign q_scaled = {1'b0, quo, 3'b000};
  always_comb begin
    if (sat) begin
      duty_c = neg ? DUTY_BOT : DUTY_TOP;
    end else if (neg) begin
      duty_c = DUTY_MID - q_scaled;
    end else begin
      duty_c = DUTY_MID + q_scaled;
    end
  end

  assign out_busy      = out_valid && !out_ready;
  assign stat.out_busy = out_busy;

  // Working registers, stepped by the current micro-op.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (ctrl.take) begin
          sp <= set_point;
          pv <= process_value;
        end
      end
      OP_PREP: begin
        err <= err_c;
        tmp <= tmp_c;
        dif <= dif_c;
      end
      OP_MUL_P: begin
        prod <= mul_p;
        p_hi <= (err_x > lim_e);
        p_lo <= (err_x < -lim_e);
        i_hi <= (tmp > lim_s);
        i_lo <= (tmp < -lim_s);
      end
      OP_MUL_I: begin
        prod <= mul_p;
        acc  <= pterm;
      end
      OP_MUL_D: begin
        prod <= mul_p;
        acc  <= acc + iterm;
      end
      OP_ADD_D: begin
        acc <= acc + prod_x;
      end
      OP_ABS: begin
        neg <= acc[ACC_W-1];
        acc <= acc[ACC_W-1] ? -acc : acc;
      end
      OP_CMP: begin
        sat <= ($unsigned(acc) >= div_lim);
        rem <= acc[REM_W-1:0];
        dvs <= {1'b0, divisor, {(QUO_W-1){1'b0}}};
        quo <= '0;
      end
      OP_DIV: begin
        // One restoring step: subtract the shifted divisor where it fits.
        if (rem >= dvs) begin
          rem <= rem - dvs;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
      end
      OP_OUT: begin
        if (!out_busy) begin
          duty_out <= duty_c;
        end
      end
      default: begin
      end
    endcase
  end

  // Controller state and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      last_sample <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.op == OP_PREP) begin
        last_sample <= pv;
      end
      // Anti-windup: the sum is held at the bound while it is clamped.
      if (ctrl.op == OP_MUL_P) begin
        if (tmp > lim_s) begin
          error_sum <= lim_s[SUM_W-1:0];
        end else if (tmp < -lim_s) begin
          error_sum <= SUM_W'(-lim_s);
        end else begin
          error_sum <= tmp[SUM_W-1:0];
        end
      end
      if (ctrl.op == OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pid_duty_controller_unit.sv =====
// Each request runs through the control program in order: prepare, the P,
// I and D multiplies, the D add, magnitude, compare, the 12-step serial
// divide loop and output, after which the next request can be taken.
// A waiting result does not block the next request from being accepted.
// Reset (rst, synchronous) clears the error sum, the last sample and the
// output valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
// pid_duty_controller_unit: discrete PID controller with anti-windup
// Turns a setpoint and a measured sample into a Q0.16 duty fraction using a
// microcoded sequencer that drives a shared multiply and divide datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_duty_controller_unit
  import pdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] set_point,
  input  wire logic [SAMPLE_WIDTH-1:0] process_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [DUTY_W-1:0]            duty_out
);

  logic [GAIN_W-1:0] p_gain;
  logic [GAIN_W-1:0] i_gain;
  logic [GAIN_W-1:0] d_gain;
  logic [GAIN_W-1:0] scale_factor;
  logic [LIM_W-1:0]  max_error;
  logic [LIM_W-1:0]  max_sum_error;
  logic [LIM_W-1:0]  i_term_cap;
  ctrl_t             ctrl;
  stat_t             stat;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain        <= '0;
      i_gain        <= '0;
      d_gain        <= '0;
      scale_factor  <= GAIN_W'(1);
      max_error     <= LIM_MAX;
      max_sum_error <= LIM_MAX;
      i_term_cap    <= LIM_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_P_GAIN:        p_gain        <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN:        i_gain        <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:        d_gain        <= cfg_data[GAIN_W-1:0];
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[GAIN_W-1:0];
        REG_MAX_ERROR:     max_error     <= cfg_data[LIM_W-1:0];
        REG_MAX_SUM_ERROR: max_sum_error <= cfg_data[LIM_W-1:0];
        REG_MAX_I_TERM:    i_term_cap    <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control program.
  pdc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // Arithmetic and state.
  pdc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .set_point     (set_point),
    .process_value (process_value),
    .p_gain        (p_gain),
    .i_gain        (i_gain),
    .d_gain        (d_gain),
    .scale_factor  (scale_factor),
    .max_error     (max_error),
    .max_sum_error (max_sum_error),
    .i_term_cap    (i_term_cap),
    .out_ready     (out_ready),
    .stat          (stat),
    .out_valid     (out_valid),
    .duty_out      (duty_out)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PID duty controller
// Sends setpoint and sample requests over a valid/ready channel under varying
// gain and limit settings. A local model of the controller predicts every
// duty value, and each returned duty is checked in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import pdc_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int END_CYCLES  = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 104;

  // Index outside the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PULSED
  } rx_mode_t;

  typedef struct packed {
    logic [15:0] sp;
    logic [15:0] pv;
  } sample_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] set_point = '0;
  logic [15:0] process_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] duty_out;

  pid_duty_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .set_point     (set_point),
    .process_value (process_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .duty_out      (duty_out)
  );

  // Local copy of the register file, at reset values.
  logic [GAIN_W-1:0] kp = '0;
  logic [GAIN_W-1:0] ki = '0;
  logic [GAIN_W-1:0] kd = '0;
  logic [GAIN_W-1:0] kscale = 15'd1;
  logic [LIM_W-1:0]  err_lim = LIM_MAX;
  logic [LIM_W-1:0]  sum_lim = LIM_MAX;
  logic [LIM_W-1:0]  iterm_lim = LIM_MAX;

  // Local copy of the controller state.
  logic signed [31:0] integ_sum = '0;
  logic [15:0]        prev_pv = '0;

  sample_t     sample_q[$];
  logic [15:0] duty_exp_q[$];

  int n_posted = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_fail = 0;
  int n_settings = 0;
  logic in_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Computes the duty for one request and advances the local state.
  function automatic logic [15:0] predict_duty(input logic [15:0] sp, input logic [15:0] pv);
    longint err, lim_e, lim_s, p_t, i_t, d_t, acc, nxt, dv, q, duty;
    err = longint'(sp) - longint'(pv);
    lim_e = longint'(err_lim);
    lim_s = longint'(sum_lim);
    if (err > lim_e) begin
      p_t = 64'sd2147483647;
    end else if (err < -lim_e) begin
      p_t = -64'sd2147483647;
    end else begin
      p_t = longint'(kp) * err;
    end
    // Anti-windup: while the sum is clamped, the I-term cap replaces the integral product.
    nxt = longint'(integ_sum) + err;
    if (nxt > lim_s) begin
      i_t = longint'(iterm_lim);
      integ_sum = 32'(lim_s);
    end else if (nxt < -lim_s) begin
      i_t = -longint'(iterm_lim);
      integ_sum = 32'(-lim_s);
    end else begin
      integ_sum = 32'(nxt);
      i_t = longint'(ki) * nxt;
    end
    d_t = longint'(kd) * (longint'(prev_pv) - longint'(pv));
    prev_pv = pv;
    acc = p_t + i_t + d_t;
    dv = (kscale == '0) ? 64'sd1 : longint'(kscale);
    q = acc / dv;
    if (q > 64'sd1000000) q = 64'sd1000000;
    if (q < -64'sd1000000) q = -64'sd1000000;
    duty = 64'sd32768 + 64'sd8 * q;
    if (duty > 64'sd65535) duty = 64'sd65535;
    if (duty < 64'sd0) duty = 64'sd0;
    return duty[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    n_fail++;
  endtask

  // Writes one register, with junk above the register width, and mirrors it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] word;
    word = $urandom();
    case (idx)
      REG_P_GAIN, REG_I_GAIN, REG_D_GAIN, REG_SCALE_FACTOR: begin
        word = (word & ~32'h0000_7FFF) | (value & 32'h0000_7FFF);
      end
      REG_MAX_ERROR, REG_MAX_SUM_ERROR, REG_MAX_I_TERM: begin
        word = (word & 32'h8000_0000) | (value & 32'h7FFF_FFFF);
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_P_GAIN:        kp = word[GAIN_W-1:0];
      REG_I_GAIN:        ki = word[GAIN_W-1:0];
      REG_D_GAIN:        kd = word[GAIN_W-1:0];
      REG_SCALE_FACTOR:  kscale = word[GAIN_W-1:0];
      REG_MAX_ERROR:     err_lim = word[LIM_W-1:0];
      REG_MAX_SUM_ERROR: sum_lim = word[LIM_W-1:0];
      REG_MAX_I_TERM:    iterm_lim = word[LIM_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic post_sample(input logic [15:0] sp, input logic [15:0] pv);
    sample_t s;
    s.sp = sp;
    s.pv = pv;
    sample_q.push_back(s);
    n_posted++;
  endtask

  // Waits until every posted request is taken and every duty has returned.
  task automatic settle();
    while (!(n_accepted == n_posted && duty_exp_q.size() == 0)) @(negedge clk);
    n_settings++;
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd32767;
      default: return $urandom_range(0, 32767) >> $urandom_range(0, 14);
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return {1'b0, LIM_MAX};
      default: return ($urandom() & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
    endcase
  endfunction

  // Monitor: predicts on each accepted request and checks each accepted duty.
  always @(posedge clk) begin
    logic [15:0] want;
    in_fire <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (duty_exp_q.size() == 0) begin
        report_mismatch($sformatf("duty %0d returned with no request pending", duty_out));
      end else begin
        want = duty_exp_q.pop_front();
        if (duty_out !== want) begin
          report_mismatch($sformatf("result %0d: duty_out %0d, expected %0d",
                                    n_results, duty_out, want));
        end
      end
      n_results <= n_results + 1;
    end
    if (!rst && in_valid && in_ready) begin
      duty_exp_q.push_back(predict_duty(set_point, process_value));
      n_accepted <= n_accepted + 1;
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    sample_t cur;
    if (!in_valid || in_fire) begin
      if (rst || gap_left != 0 || sample_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        cur = sample_q.pop_front();
        set_point <= cur.sp;
        process_value <= cur.pv;
        in_valid <= 1'b1;
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end
      end
    end
  end

  // Result receiver: switches between stall patterns over windows of cycles.
  rx_mode_t rx_mode = RX_ALWAYS;
  int rx_window = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    if (rx_window == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_window = $urandom_range(16, 120);
    end
    rx_window--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= (rx_tick % 17) < 4;
    endcase
  end

  // Watchdog on cycles in which no handshake completes.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence: directed settings first, then random phases.
  initial begin
    logic [15:0] sp, pv;
    int delta, nxt_pv;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero scale factor, error exactly at and just past the P bound,
    // sample extremes, and a write to an unmapped index.
    write_reg(REG_P_GAIN, 32'd3);
    write_reg(REG_I_GAIN, 32'd0);
    write_reg(REG_D_GAIN, 32'd2);
    write_reg(REG_SCALE_FACTOR, 32'd0);
    write_reg(REG_MAX_ERROR, 32'd1000);
    write_reg(REG_MAX_SUM_ERROR, {1'b0, LIM_MAX});
    write_reg(REG_MAX_I_TERM, {1'b0, LIM_MAX});
    write_reg(REG_UNUSED, 32'd0);
    @(posedge clk);
    post_sample(16'd0, 16'd0);
    post_sample(16'hFFFF, 16'd0);
    post_sample(16'd0, 16'hFFFF);
    post_sample(16'd1000, 16'd0);
    post_sample(16'd0, 16'd1000);
    post_sample(16'd1001, 16'd0);
    post_sample(16'd0, 16'd1001);
    post_sample(16'd500, 16'd500);
    post_sample(16'hFFFF, 16'hFFFF);
    settle();

    // Integral sum reaching its bound exactly, then clamping either way.
    write_reg(REG_P_GAIN, 32'd0);
    write_reg(REG_I_GAIN, 32'd1);
    write_reg(REG_D_GAIN, 32'd0);
    write_reg(REG_SCALE_FACTOR, 32'd4);
    write_reg(REG_MAX_ERROR, {1'b0, LIM_MAX});
    write_reg(REG_MAX_SUM_ERROR, 32'd500);
    write_reg(REG_MAX_I_TERM, 32'd300);
    @(posedge clk);
    post_sample(16'd250, 16'd0);
    post_sample(16'd250, 16'd0);
    post_sample(16'd1, 16'd0);
    post_sample(16'd0, 16'd1000);
    post_sample(16'd0, 16'd1);
    post_sample(16'd0, 16'hFFFF);
    post_sample(16'hFFFF, 16'd0);
    settle();

    // Registers at their extremes: full gains and divisor, zero limits.
    write_reg(REG_P_GAIN, 32'd32767);
    write_reg(REG_I_GAIN, 32'd32767);
    write_reg(REG_D_GAIN, 32'd32767);
    write_reg(REG_SCALE_FACTOR, 32'd32767);
    write_reg(REG_MAX_ERROR, 32'd0);
    write_reg(REG_MAX_SUM_ERROR, 32'd0);
    write_reg(REG_MAX_I_TERM, 32'd0);
    @(posedge clk);
    post_sample(16'd0, 16'd0);
    post_sample(16'hFFFF, 16'd0);
    post_sample(16'd0, 16'hFFFF);
    post_sample(16'd12345, 16'd12346);
    post_sample(16'd40000, 16'd40000);
    settle();

    // Random settings; samples mostly track a setpoint, the rest are noise.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_P_GAIN, rand_gain());
      write_reg(REG_I_GAIN, rand_gain());
      write_reg(REG_D_GAIN, rand_gain());
      write_reg(REG_SCALE_FACTOR, rand_gain());
      write_reg(REG_MAX_ERROR, rand_limit());
      write_reg(REG_MAX_SUM_ERROR, rand_limit());
      write_reg(REG_MAX_I_TERM, rand_limit());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 32'd0);
      @(posedge clk);
      sp = 16'($urandom());
      pv = 16'($urandom());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 15) == 0) sp = 16'($urandom());
          delta = int'($urandom_range(0, 400)) - 200;
          nxt_pv = int'(pv) + delta;
          if (nxt_pv < 0) nxt_pv = 0;
          if (nxt_pv > 65535) nxt_pv = 65535;
          pv = nxt_pv[15:0];
        end else begin
          sp = 16'($urandom());
          pv = 16'($urandom());
        end
        post_sample(sp, pv);
      end
      settle();
    end

    repeat (END_CYCLES) @(posedge clk);
    $display("Ran %0d requests under %0d register settings; %0d duty values checked.",
             n_accepted, n_settings, n_results);
    $display("Mismatches found: %0d", n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
